// ===== sv/mail_body_end_marker_unstuffer_top_assert.svh =====
// assertion macros shared by the unstuffer modules
// each module that asserts has clk and rst_n in scope
`ifndef MAIL_BODY_END_MARKER_UNSTUFFER_TOP_ASSERT_SVH
`define MAIL_BODY_END_MARKER_UNSTUFFER_TOP_ASSERT_SVH

// same-cycle implication
`define MBEU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MBEU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mbeu_pkg.sv =====
`timescale 1ns / 1ps
package mbeu_pkg;

    // end-of-body marker bytes
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_DOT = 8'h2e;

    // request opcodes
    localparam logic [1:0] OP_DATA = 2'd0;
    localparam logic [1:0] OP_BODY = 2'd1;
    localparam logic [1:0] OP_LIST = 2'd2;

    typedef logic [2:0] mcount_t;

    localparam mcount_t   MARK_FULL   = 3'd5;
    localparam mcount_t   MARK_MAX    = 3'd4;
    localparam mcount_t   LIST_PRESET = 3'd2;
    localparam logic [1:0] LIST_STRIP = 2'd2;

    // descriptor queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_BYTE,
        TAIL_DONE
    } tail_t;

    // one run of results: marker bytes [first, stop) then the tail
    typedef struct packed {
        mcount_t     first;
        mcount_t     stop;
        tail_t       tail;
        logic [7:0]  data;
    } run_desc_t;

    function automatic logic [7:0] marker_byte(input mcount_t idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = CH_CR;
            3'd1:    b = CH_LF;
            3'd2:    b = CH_DOT;
            3'd3:    b = CH_CR;
            3'd4:    b = CH_LF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== sv/mbeu_front.sv =====
`timescale 1ns / 1ps
`include "mail_body_end_marker_unstuffer_top_assert.svh"
module mbeu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          op,
    input  logic [7:0]          data_byte,
    input  logic                q_full,
    output logic                push,
    output mbeu_pkg::run_desc_t push_desc
);
    import mbeu_pkg::*;

    mcount_t    match_count_reg, match_count_next;
    logic [1:0] strip_left_reg, strip_left_next;
    mcount_t    prev, nxt, skip, stop, strip_ext, strip_diff;
    logic       dot_drop;
    logic       accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    // match tracking
    always_comb
    begin
        prev     = (match_count_reg > MARK_MAX) ? 3'd0 : match_count_reg;
        dot_drop = 1'b0;
        priority if (data_byte == CH_CR)
        begin
            nxt = (prev == 3'd0 || prev == 3'd3) ? prev + 3'd1 : 3'd1;
        end
        else if (data_byte == CH_LF)
        begin
            nxt = (prev == 3'd1 || prev == 3'd4) ? prev + 3'd1 : 3'd0;
        end
        else if (data_byte == CH_DOT)
        begin
            nxt      = (prev == 3'd2) ? 3'd3 : 3'd0;
            dot_drop = (prev == 3'd3);
        end
        else
        begin
            nxt = 3'd0;
        end
        strip_ext  = {1'b0, strip_left_reg};
        skip       = (strip_ext < prev) ? strip_ext : prev;
        strip_diff = strip_ext - skip;
        stop       = dot_drop ? prev - 3'd1 : prev;
    end

    always_comb
    begin
        match_count_next = match_count_reg;
        strip_left_next  = strip_left_reg;
        push             = 1'b0;
        push_desc.first  = 3'd0;
        push_desc.stop   = 3'd0;
        push_desc.tail   = (nxt == 3'd0) ? TAIL_BYTE : TAIL_NONE;
        push_desc.data   = data_byte;
        if (accept)
        begin
            unique case (op)
                OP_BODY:
                begin
                    match_count_next = 3'd0;
                    strip_left_next  = 2'd0;
                end
                OP_LIST:
                begin
                    match_count_next = LIST_PRESET;
                    strip_left_next  = LIST_STRIP;
                end
                OP_DATA:
                begin
                    priority if (nxt == MARK_FULL)
                    begin
                        match_count_next = 3'd0;
                        strip_left_next  = 2'd0;
                        push             = 1'b1;
                        push_desc.tail   = TAIL_DONE;
                        push_desc.data   = 8'h00;
                    end
                    else if (prev != 3'd0 && nxt <= prev)
                    begin
                        strip_left_next  = strip_diff[1:0];
                        match_count_next = nxt;
                        push_desc.first  = skip;
                        push_desc.stop   = stop;
                        push             = (skip < stop) || (nxt == 3'd0);
                    end
                    else
                    begin
                        match_count_next = nxt;
                        push             = (nxt == 3'd0);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_count_reg <= 3'd0;
            strip_left_reg  <= 2'd0;
        end
        else
        begin
            match_count_reg <= match_count_next;
            strip_left_reg  <= strip_left_next;
        end
    end

    `MBEU_ASSERT_NOW(a_count_range, 1'b1, match_count_reg <= MARK_MAX, "match count out of range")
    `MBEU_ASSERT_NEXT(a_done_clears, push && push_desc.tail == TAIL_DONE, match_count_reg == 3'd0, "full match left state")

endmodule

// ===== sv/mbeu_fifo.sv =====
`timescale 1ns / 1ps
`include "mail_body_end_marker_unstuffer_top_assert.svh"
module mbeu_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mbeu_pkg::run_desc_t push_desc,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output mbeu_pkg::run_desc_t head
);
    import mbeu_pkg::*;

    run_desc_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;

    assign full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    `MBEU_ASSERT_NOW(a_no_overflow, push, !full, "push into full queue")
    `MBEU_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

// ===== sv/mbeu_back.sv =====
`timescale 1ns / 1ps
`include "mail_body_end_marker_unstuffer_top_assert.svh"
module mbeu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  mbeu_pkg::run_desc_t q_head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_byte,
    output logic                byte_valid,
    output logic                body_done,
    output logic                run_last
);
    import mbeu_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic       started_reg, started_next;
    mcount_t    pos_reg, pos_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       byte_valid_reg, byte_valid_next;
    logic       body_done_reg, body_done_next;
    logic       run_last_reg, run_last_next;
    logic       load;
    mcount_t    cur;

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign body_done  = body_done_reg;
    assign run_last   = run_last_reg;

    assign load = !out_valid_reg || !out_stall;
    assign cur  = started_reg ? pos_reg : q_head.first;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        started_next    = started_reg;
        pos_next        = pos_reg;
        out_byte_next   = out_byte_reg;
        byte_valid_next = byte_valid_reg;
        body_done_next  = body_done_reg;
        run_last_next   = run_last_reg;
        pop             = 1'b0;
        if (load)
        begin
            out_valid_next = !q_empty;
            if (!q_empty)
            begin
                if (cur < q_head.stop)
                begin
                    // held marker byte
                    out_byte_next   = marker_byte(cur);
                    byte_valid_next = 1'b1;
                    body_done_next  = 1'b0;
                    run_last_next   = (cur + 3'd1 == q_head.stop) && (q_head.tail == TAIL_NONE);
                    pop             = run_last_next;
                    started_next    = !run_last_next;
                    pos_next        = cur + 3'd1;
                end
                else
                begin
                    started_next  = 1'b0;
                    pop           = 1'b1;
                    run_last_next = 1'b1;
                    unique case (q_head.tail)
                        TAIL_BYTE:
                        begin
                            out_byte_next   = q_head.data;
                            byte_valid_next = 1'b1;
                            body_done_next  = 1'b0;
                        end
                        TAIL_DONE:
                        begin
                            out_byte_next   = 8'h00;
                            byte_valid_next = 1'b0;
                            body_done_next  = 1'b1;
                        end
                        default:
                        begin
                            out_byte_next   = 8'h00;
                            byte_valid_next = 1'b0;
                            body_done_next  = 1'b0;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        out_byte_reg   <= out_byte_next;
        byte_valid_reg <= byte_valid_next;
        body_done_reg  <= body_done_next;
        run_last_reg   <= run_last_next;
    end

    `MBEU_ASSERT_NOW(a_done_shape, out_valid_reg && body_done_reg, !byte_valid_reg && run_last_reg, "end of body result malformed")
    `MBEU_ASSERT_NOW(a_run_has_head, started_reg, !q_empty, "run in progress without queue head")

endmodule

// ===== sv/mail_body_end_marker_unstuffer_top.sv =====
// mail body end-marker unstuffer
// input channel (in_valid / in_stall): one request per op; op data carries a body byte,
//   op start-body clears the marker match, op start-listing presets a leading cr lf
//   that is then never delivered; chunk_last is carried for the sender only
// output channel (out_valid / out_stall): one result per cycle unless out_stall holds it;
//   a result is a body byte (byte_valid), or the end-of-body report (body_done); run_last
//   closes the results of one request, requests that only extend a match give none
// the front tracks the cr lf dot cr lf match and turns each request that gives results
//   into a run descriptor; a four-entry queue parts it from the back, which spells a run
//   out into the output register one result at a time
// path: a taken request's descriptor is written into the queue, and the back then moves
//   its results from the queue head into the output register
// throughput: one request per cycle while the queue has room; results leave one per cycle
//   while out_stall is low, so each held marker byte that a request releases is one result
// in_stall rises only when the queue is full; out_stall holds a valid output register and
//   the queue keeps taking requests until it fills
// reset: match state cleared, queue empty, no result pending
`timescale 1ns / 1ps
module mail_body_end_marker_unstuffer_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] op,
    input  logic [7:0] data_byte,
    input  logic       chunk_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       body_done,
    output logic       run_last
);
    import mbeu_pkg::*;

    // descriptor queue handshake
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_empty;
    run_desc_t q_in;
    run_desc_t q_head;

    // match tracking and classification
    mbeu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .data_byte (data_byte),
        .q_full    (q_full),
        .push      (q_push),
        .push_desc (q_in)
    );

    // short queue so either side can stall on its own
    mbeu_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // run expansion and output register
    mbeu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .body_done  (body_done),
        .run_last   (run_last)
    );

endmodule
